// ===== sv/format_duration_text_assert.svh =====
// ------------------------------------------------------------------
// assertion macros for the duration text formatter
// ------------------------------------------------------------------
`ifndef FORMAT_DURATION_TEXT_ASSERT_SVH
`define FORMAT_DURATION_TEXT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FDT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FDT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FDT_ASSERT(label, clk, rst_n, prop, msg)
`define FDT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/fmtd_pkg.sv =====
// ------------------------------------------------------------------
// fmtd_pkg
// shared types, constants and the character slot table
// ------------------------------------------------------------------
package fmtd_pkg;

	localparam int MAG_W = 63;
	localparam int NDIG = 20;
	localparam int DIG_W = NDIG * 4;
	localparam int NCELL = MAG_W;
	localparam int SLOT_W = 5;

	localparam logic [6:0] CH_MINUS = 7'h2d;
	localparam logic [6:0] CH_COLON = 7'h3a;
	localparam logic [6:0] CH_DOT = 7'h2e;
	localparam logic [6:0] CH_UNDER = 7'h5f;
	localparam logic [6:0] CH_ZERO = 7'h30;

	// template slots
	localparam logic [SLOT_W-1:0] SL_MINUS = 5'd0;
	localparam logic [SLOT_W-1:0] SL_SEC_END = 5'd13;
	localparam logic [SLOT_W-1:0] SL_MS_END = 5'd17;
	localparam logic [SLOT_W-1:0] SL_US_END = 5'd21;
	localparam logic [SLOT_W-1:0] SL_NS_END = 5'd25;

	typedef struct packed {
		logic valid;
		logic miss;
		logic neg;
		logic [MAG_W-1:0] mag;
		logic [DIG_W-1:0] dig;
	} fmtd_cell_t;

	// half the radix of each mixed-radix digit: tens of minutes and seconds are base 6
	function automatic logic [3:0] half_radix(input int j);
		half_radix = (j == 10 || j == 12) ? 4'd3 : 4'd5;
	endfunction

	function automatic logic [6:0] digit_char(input logic [DIG_W-1:0] dig, input int j);
		digit_char = CH_ZERO + {3'b000, dig[j*4 +: 4]};
	endfunction

	// digit order low to high: ns, us, ms (3 each), s0, s1, m0, m1, h0..h6
	function automatic logic [6:0] slot_char(input logic [SLOT_W-1:0] t,
			input logic [DIG_W-1:0] dig);
		logic [6:0] c;
		c = CH_ZERO;
		case (t)
			5'd0: c = CH_MINUS;
			5'd1: c = digit_char(dig, 19);
			5'd2: c = digit_char(dig, 18);
			5'd3: c = digit_char(dig, 17);
			5'd4: c = digit_char(dig, 16);
			5'd5: c = digit_char(dig, 15);
			5'd6: c = digit_char(dig, 14);
			5'd7: c = digit_char(dig, 13);
			5'd8: c = CH_COLON;
			5'd9: c = digit_char(dig, 12);
			5'd10: c = digit_char(dig, 11);
			5'd11: c = CH_COLON;
			5'd12: c = digit_char(dig, 10);
			5'd13: c = digit_char(dig, 9);
			5'd14: c = CH_DOT;
			5'd15: c = digit_char(dig, 8);
			5'd16: c = digit_char(dig, 7);
			5'd17: c = digit_char(dig, 6);
			5'd18: c = CH_UNDER;
			5'd19: c = digit_char(dig, 5);
			5'd20: c = digit_char(dig, 4);
			5'd21: c = digit_char(dig, 3);
			5'd22: c = CH_UNDER;
			5'd23: c = digit_char(dig, 2);
			5'd24: c = digit_char(dig, 1);
			5'd25: c = digit_char(dig, 0);
			default: c = CH_ZERO;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/fmtd_cell.sv =====
// ------------------------------------------------------------------
// fmtd_cell
// one doubling step of the mixed-radix conversion, one magnitude bit in
// ------------------------------------------------------------------
module fmtd_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  fmtd_pkg::fmtd_cell_t d,
	output fmtd_pkg::fmtd_cell_t q
);

	logic [fmtd_pkg::NDIG-1:0] carry;
	logic [fmtd_pkg::DIG_W-1:0] dig_nx;

	// carry out of each digit depends on that digit alone, so no ripple
	always_comb begin
		logic [3:0] h;
		logic [3:0] v;
		logic [3:0] r;
		logic cin;
		dig_nx = '0;
		for (int j = 0; j < fmtd_pkg::NDIG; j++) begin
			h = fmtd_pkg::half_radix(j);
			v = d.dig[j*4 +: 4];
			carry[j] = (v >= h);
			cin = (j == 0) ? d.mag[fmtd_pkg::MAG_W-1] : carry[(j == 0) ? 0 : j-1];
			r = carry[j] ? (v - h) : v;
			dig_nx[j*4 +: 4] = {r[2:0], cin};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.miss <= d.miss;
			q.neg <= d.neg;
			q.mag <= {d.mag[fmtd_pkg::MAG_W-2:0], 1'b0};
			q.dig <= dig_nx;
		end
	end

endmodule

// ===== sv/fmtd_ser.sv =====
// ------------------------------------------------------------------
// fmtd_ser
// holds one converted request and sends its text a character a cycle while the receiver takes them
// ------------------------------------------------------------------
module fmtd_ser (
	input  logic clk,
	input  logic arst_n,
	input  fmtd_pkg::fmtd_cell_t d,
	output logic ready,
	output logic [6:0] char_code,
	output logic missing_flag,
	output logic last,
	output logic valid,
	input  logic take
);

	logic valid_q;
	logic miss_q;
	logic [fmtd_pkg::DIG_W-1:0] dig_q;
	logic [fmtd_pkg::SLOT_W-1:0] t_q;
	logic [fmtd_pkg::SLOT_W-1:0] skip_q;
	logic [fmtd_pkg::SLOT_W-1:0] end_q;
	logic [fmtd_pkg::SLOT_W-1:0] skip_nx;
	logic [fmtd_pkg::SLOT_W-1:0] end_nx;
	logic load;

	// first hour slot: seven hour slots, at least two digits shown
	always_comb begin
		skip_nx = 5'd5;
		for (int j = 15; j <= 19; j++) begin
			if (d.dig[j*4 +: 4] != 4'd0) skip_nx = 5'(19 - j);
		end
		if (d.dig[3:0] != 4'd0 || d.dig[7:4] != 4'd0 || d.dig[11:8] != 4'd0)
			end_nx = fmtd_pkg::SL_NS_END;
		else if (d.dig[23:12] != 12'd0)
			end_nx = fmtd_pkg::SL_US_END;
		else if (d.dig[35:24] != 12'd0)
			end_nx = fmtd_pkg::SL_MS_END;
		else
			end_nx = fmtd_pkg::SL_SEC_END;
	end

	assign last = miss_q || (t_q == end_q);
	assign ready = !valid_q || (take && last);
	assign load = d.valid && ready;
	assign valid = valid_q;
	assign missing_flag = miss_q;
	assign char_code = miss_q ? 7'd0 : fmtd_pkg::slot_char(t_q, dig_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			t_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			t_q <= d.neg ? fmtd_pkg::SL_MINUS : (skip_nx + 5'd1);
		end else if (take) begin
			if (last) valid_q <= 1'b0;
			else t_q <= (t_q == fmtd_pkg::SL_MINUS) ? (skip_q + 5'd1) : (t_q + 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			miss_q <= d.miss;
			dig_q <= d.dig;
			skip_q <= skip_nx;
			end_q <= end_nx;
		end
	end

endmodule

// ===== sv/format_duration_text.sv =====
// ------------------------------------------------------------------
// format_duration_text
// signed nanosecond duration to text, one ascii character per beat
// ------------------------------------------------------------------
// requests arrive on the s_ channel as 64-bit two's complement counts;
// the text leaves on the m_ channel one character a beat, tlast on the
// final character, tuser set for the missing marker (one beat, char 0).
// a chain of 63 cells takes one magnitude bit each, doubling a mixed
// radix number (hours, minutes, seconds, milli, micro, nano digits).
// the chain accepts a request every cycle while it can move; the
// character output then sets the pace: each request holds it for the
// length of its text, 8 to 26 characters (one for the missing marker),
// with no gap between requests. a stalled receiver holds the current
// character and, once the last cell holds a request, freezes the chain,
// which then drops tready. reset empties the chain and the output stage.
// ------------------------------------------------------------------
`include "format_duration_text_assert.svh"

module format_duration_text (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,	// duration_ns
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,	// char_code, one zero bit
	output logic m_tuser,	// missing_flag
	output logic m_tlast	// last
);

	fmtd_pkg::fmtd_cell_t link [0:fmtd_pkg::NCELL];
	logic en;
	logic ser_ready;
	logic [6:0] char_code;
	logic [63:0] mag64;

	assign en = ser_ready || !link[fmtd_pkg::NCELL].valid;
	assign s_tready = en;
	assign mag64 = s_tdata[63] ? (~s_tdata + 64'd1) : s_tdata;

	always_comb begin
		link[0].valid = s_tvalid && en;
		link[0].miss = (s_tdata == {1'b1, 63'd0});
		link[0].neg = s_tdata[63];
		link[0].mag = mag64[fmtd_pkg::MAG_W-1:0];
		link[0].dig = '0;
	end

	for (genvar i = 0; i < fmtd_pkg::NCELL; i++) begin : g_cell
		fmtd_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.d(link[i]),
			.q(link[i+1])
		);
	end

	fmtd_ser u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.d(link[fmtd_pkg::NCELL]),
		.ready(ser_ready),
		.char_code(char_code),
		.missing_flag(m_tuser),
		.last(m_tlast),
		.valid(m_tvalid),
		.take(m_tready)
	);

	assign m_tdata = {1'b0, char_code};

	`FDT_ASSERT(a_miss_single, clk, arst_n, m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0, "missing beat not alone")
	`FDT_NEVER(a_text_nonzero, clk, arst_n, m_tvalid && !m_tuser && m_tdata == 8'd0, "null character in text")
	`FDT_ASSERT(a_frozen, clk, arst_n, !s_tready |-> link[fmtd_pkg::NCELL].valid && m_tvalid, "chain stalled without cause")

endmodule

// ===== tb/sv/tb_format_duration_text.sv =====
// ------------------------------------------------------------------
// tb_format_duration_text
// checks the duration text formatter against an in-bench predictor
// ------------------------------------------------------------------
// signed nanosecond counts go in on the s_ channel; each character that
// comes out on the m_ channel is checked against the text predicted for
// the oldest request still pending. both sides idle at random.
// ------------------------------------------------------------------
module tb_format_duration_text;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [63:0] MISSING_NS = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [6:0] char_code;
		logic missing_flag;
		logic last;
	} text_char_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	logic [63:0] pending_ns[$];
	text_char_t expected_text[$];
	int send_gap;
	int recv_gap;
	int cycles;
	int errors;
	bit stim_done;

	format_duration_text u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic text_char_t mk_char(input logic [6:0] c);
		text_char_t t;
		t.char_code = c;
		t.missing_flag = 1'b0;
		t.last = 1'b0;
		return t;
	endfunction

	task automatic push_three(input int v);
		expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'((v / 100) % 10)));
		expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'((v / 10) % 10)));
		expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'(v % 10)));
	endtask

	// builds the whole text for one duration onto the expected queue
	task automatic predict_text(input logic [63:0] raw);
		logic [63:0] mag;
		logic [63:0] secs;
		logic [63:0] hours;
		int frac, ms, us, ns, mins, sec;
		int hdig[$];
		text_char_t t;
		if (raw == MISSING_NS) begin
			t.char_code = 7'd0;
			t.missing_flag = 1'b1;
			t.last = 1'b1;
			expected_text.push_back(t);
			return;
		end
		mag = raw;
		if (raw[63]) begin
			expected_text.push_back(mk_char(fmtd_pkg::CH_MINUS));
			mag = -raw;
		end
		secs = mag / 64'd1000000000;
		frac = int'(mag % 64'd1000000000);
		hours = secs / 64'd3600;
		mins = int'((secs % 64'd3600) / 64'd60);
		sec = int'(secs % 64'd60);
		ms = frac / 1000000;
		us = (frac / 1000) % 1000;
		ns = frac % 1000;
		do begin
			hdig.push_front(int'(hours % 64'd10));
			hours = hours / 64'd10;
		end while (hours != 0);
		if (hdig.size() < 2)
			hdig.push_front(0);
		foreach (hdig[i])
			expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'(hdig[i])));
		expected_text.push_back(mk_char(fmtd_pkg::CH_COLON));
		expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'(mins / 10)));
		expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'(mins % 10)));
		expected_text.push_back(mk_char(fmtd_pkg::CH_COLON));
		expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'(sec / 10)));
		expected_text.push_back(mk_char(fmtd_pkg::CH_ZERO + 7'(sec % 10)));
		if (frac != 0) begin
			expected_text.push_back(mk_char(fmtd_pkg::CH_DOT));
			push_three(ms);
			if (us != 0 || ns != 0) begin
				expected_text.push_back(mk_char(fmtd_pkg::CH_UNDER));
				push_three(us);
				if (ns != 0) begin
					expected_text.push_back(mk_char(fmtd_pkg::CH_UNDER));
					push_three(ns);
				end
			end
		end
		expected_text[$].last = 1'b1;
	endtask

	function automatic logic [63:0] rand_duration();
		logic [63:0] v;
		logic [63:0] ns_part;
		int kind;
		kind = $urandom_range(0, 9);
		v = {$urandom(), $urandom()};
		ns_part = 64'($urandom_range(0, 999));
		case (kind)
			0: v = v;
			1: v = v >> $urandom_range(0, 63);
			2: v = 64'($urandom_range(0, 359999)) * 64'd1000000000;
			3: v = 64'($urandom_range(0, 359999)) * 64'd1000000000
				+ 64'($urandom_range(0, 999)) * 64'd1000000;
			4: v = 64'($urandom_range(0, 99999)) * 64'd1000000000
				+ 64'($urandom_range(0, 999999)) * 64'd1000;
			5: v = 64'($urandom_range(0, 99999)) * 64'd1000000000
				+ 64'($urandom_range(0, 999999999));
			6: v = {$urandom(), $urandom()} % 64'd3600000000000;
			7: v = MISSING_NS + 64'($urandom_range(0, 3));
			8: v = 64'hFFFF_FFFF_FFFF_FFFF - ns_part;
			default: v = {$urandom(), $urandom()} >> 16;
		endcase
		if (kind != 7 && kind != 8 && $urandom_range(0, 2) == 0)
			v = -v;
		return v;
	endfunction

	initial begin
		logic [63:0] directed[$];
		directed = '{
			64'd0, 64'd1, 64'd999, 64'd1000, 64'd1000000, 64'd999999999,
			64'd1000000000, 64'd59999999999, 64'd3599999999999,
			64'd3600000000000, 64'd360000000000000, 64'd1001001,
			64'd1000001, 64'd123456789,
			64'h7FFF_FFFF_FFFF_FFFF, MISSING_NS, MISSING_NS + 64'd1,
			64'hFFFF_FFFF_FFFF_FFFF, -64'd1000000000, -64'd3600000000000,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
		};
		foreach (directed[i])
			pending_ns.push_back(directed[i]);
		repeat (350)
			pending_ns.push_back(rand_duration());
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
			stim_done <= 1'b0;
		end else if (s_tvalid && !s_tready) begin
			// hold the request
		end else begin
			if (s_tvalid)
				predict_text(s_tdata);
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_ns.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_ns.pop_front();
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		text_char_t got;
		text_char_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			errors <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.char_code = m_tdata[6:0];
				got.missing_flag = m_tuser;
				got.last = m_tlast;
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected character, expected none, actual %h",
						$time, got);
					errors <= errors + 1;
				end else begin
					want = expected_text.pop_front();
					if (got !== want || m_tdata[7] !== 1'b0) begin
						$display("%0t: mismatch, expected char %h miss %b last %b, actual char %h miss %b last %b",
							$time, want.char_code, want.missing_flag, want.last,
							m_tdata, m_tuser, m_tlast);
						errors <= errors + 1;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= pick_gap();
			end
		end
	end

	initial begin
		cycles = 0;
		wait (arst_n);
		while (!(stim_done && !s_tvalid && expected_text.size() == 0)
				&& cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			repeat (200) @(posedge clk);
			if (errors == 0 && expected_text.size() == 0)
				$display("PASSED: all results match");
			else
				$display("FAILED: results differ");
			$finish;
		end
	end

endmodule
